/* design/ats_pkg.sv */
// ----------------------------------------------------------------------------
// ats_pkg
// Shared widths, register map and reset values for the actuator test
// sequencer.
// ----------------------------------------------------------------------------
package ats_pkg;

    localparam int LEVEL_W  = 12;
    localparam int COUNT_W  = 8;
    localparam int MODE_W   = 3;
    localparam int CFG_IDX_W = 3;

    // configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OVER_VOLTAGE  = 3'd0,
        CFG_UNDER_VOLTAGE = 3'd1,
        CFG_SIGNAL_HIGH   = 3'd2,
        CFG_SIGNAL_LOW    = 3'd3,
        CFG_DEBOUNCE      = 3'd4
    } cfg_index_t;

    localparam logic [LEVEL_W-1:0] OVER_VOLTAGE_RESET  = 12'd3190;
    localparam logic [LEVEL_W-1:0] UNDER_VOLTAGE_RESET = 12'd2250;
    localparam logic [LEVEL_W-1:0] SIGNAL_HIGH_RESET   = 12'd3000;
    localparam logic [LEVEL_W-1:0] SIGNAL_LOW_RESET    = 12'd1000;
    localparam logic [COUNT_W-1:0] DEBOUNCE_RESET      = 8'd5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // relay bits
    localparam int RELAY_FWD = 0;
    localparam int RELAY_BWD = 1;
    localparam int RELAY_TMR = 2;

    // feedback bits
    localparam int FB_DRV = 0;
    localparam int FB_OE  = 1;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
        sat_inc = (c == COUNT_MAX) ? c : c + COUNT_W'(1);
    endfunction

endpackage

/* design/actuator_test_sequencer.sv */
// ----------------------------------------------------------------------------
// actuator_test_sequencer
// Mode sequencer for an actuator test: supply check, control debounce,
// feedback confirm and forward/backward relay runs, plus supply monitor.
// ----------------------------------------------------------------------------
// Each input word is one pass of the control loop. A word is captured in an
// input register; when the output can advance, one pass of combinational
// logic updates the sequencer state and loads the result register, so one word
// is taken per clock cycle unless the output stalls. The result register frees
// the input side: a new word is accepted while a result waits, and the flow
// stops only when both registers are full. The user must write configuration
// limits only while the block is idle; the block does not enforce this. They
// take effect on the next pass; writes to an unused index are ignored.
module actuator_test_sequencer
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ats_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ats_pkg::LEVEL_W-1:0]   cfg_data,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          tick_second,
    input  logic                          tick_ten_ms,
    input  logic                          relay_timeout,
    input  logic [ats_pkg::LEVEL_W-1:0]   supply_level,
    input  logic                          control_level,
    input  logic                          feedback_level,
    input  logic [ats_pkg::LEVEL_W-1:0]   signal_b,
    input  logic [ats_pkg::LEVEL_W-1:0]   signal_y,
    input  logic [ats_pkg::LEVEL_W-1:0]   signal_w,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ats_pkg::MODE_W-1:0]    mode,
    output logic                          relay_forward,
    output logic                          relay_backward,
    output logic                          relay_timer_on,
    output logic                          feedback_drive,
    output logic                          feedback_output_enable,
    output logic                          power_fault
);

    typedef enum logic [ats_pkg::MODE_W-1:0] {
        MODE_VOLTCHECK = 3'd0,
        MODE_IDLE      = 3'd1,
        MODE_CONTROL   = 3'd2,
        MODE_HIGH      = 3'd3,
        MODE_LOW       = 3'd4,
        MODE_RUN_BWD   = 3'd5,
        MODE_RUN_FWD   = 3'd6,
        MODE_WRAP_UP   = 3'd7
    } mode_t;

    // configuration
    logic [ats_pkg::LEVEL_W-1:0] over_voltage_reg;
    logic [ats_pkg::LEVEL_W-1:0] under_voltage_reg;
    logic [ats_pkg::LEVEL_W-1:0] signal_high_reg;
    logic [ats_pkg::LEVEL_W-1:0] signal_low_reg;
    logic [ats_pkg::COUNT_W-1:0] debounce_reg;

    // input register
    logic                        in_valid_reg;
    logic                        tick_second_reg;
    logic                        tick_ten_ms_reg;
    logic                        relay_timeout_reg;
    logic [ats_pkg::LEVEL_W-1:0] supply_reg;
    logic                        control_reg;
    logic                        feedback_reg;
    logic [ats_pkg::LEVEL_W-1:0] signal_b_reg;
    logic [ats_pkg::LEVEL_W-1:0] signal_y_reg;
    logic [ats_pkg::LEVEL_W-1:0] signal_w_reg;

    // sequencer state
    mode_t                       mode_reg,          mode_next;
    logic                        pending_second_reg, pending_second_next;
    logic                        pending_ten_ms_reg, pending_ten_ms_next;
    logic [ats_pkg::COUNT_W-1:0] volt_count_reg,    volt_count_next;
    logic [ats_pkg::COUNT_W-1:0] high_count_reg,    high_count_next;
    logic [ats_pkg::COUNT_W-1:0] low_count_reg,     low_count_next;
    logic [ats_pkg::COUNT_W-1:0] confirm_count_reg, confirm_count_next;
    logic                        fault_reg,         fault_next;
    logic                        recheck_reg,       recheck_next;
    logic [2:0]                  relay_reg,         relay_next;
    logic [1:0]                  feedback_bits_reg, feedback_bits_next;

    // result register
    logic                        out_valid_reg;

    logic advance;
    logic step;
    logic supply_bad;
    logic in_middle;
    logic b_joins_w;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || out_ready;
    assign step      = in_valid_reg && advance;
    assign in_ready  = !in_valid_reg || advance;

    assign supply_bad = (supply_reg > over_voltage_reg) || (supply_reg < under_voltage_reg);
    assign in_middle  = (signal_b_reg >= signal_high_reg) && (signal_w_reg < signal_low_reg)
                        && (signal_y_reg < signal_low_reg);
    assign b_joins_w  = (signal_y_reg >= signal_high_reg) && (signal_b_reg < signal_low_reg)
                        && (signal_w_reg < signal_low_reg);

    // one loop pass, in the order the steps take effect
    always_comb
    begin
        mode_next           = mode_reg;
        pending_second_next = pending_second_reg || tick_second_reg;
        pending_ten_ms_next = pending_ten_ms_reg || tick_ten_ms_reg;
        volt_count_next     = volt_count_reg;
        high_count_next     = high_count_reg;
        low_count_next      = low_count_reg;
        confirm_count_next  = confirm_count_reg;
        fault_next          = fault_reg;
        recheck_next        = recheck_reg;
        relay_next          = relay_timeout_reg ? 3'b000 : relay_reg;
        feedback_bits_next  = feedback_bits_reg;

        // supply monitor, once a second then every 10 ms while rechecking
        if (mode_reg != MODE_VOLTCHECK && !fault_reg)
        begin
            if (!recheck_reg)
            begin
                if (pending_second_next)
                begin
                    pending_second_next = 1'b0;
                    if (supply_bad)
                    begin
                        volt_count_next = '0;
                        recheck_next    = 1'b1;
                    end
                end
            end
            else if (pending_ten_ms_next)
            begin
                pending_ten_ms_next = 1'b0;
                if (supply_bad)
                begin
                    volt_count_next = ats_pkg::sat_inc(volt_count_next);
                    if (volt_count_next > debounce_reg)
                    begin
                        fault_next   = 1'b1;
                        recheck_next = 1'b0;
                    end
                end
                else
                begin
                    volt_count_next = '0;
                    recheck_next    = 1'b0;
                end
            end
        end

        unique case (mode_reg)
            MODE_VOLTCHECK:
            begin
                if (pending_ten_ms_next)
                begin
                    pending_ten_ms_next = 1'b0;
                    if (supply_bad)
                    begin
                        volt_count_next = ats_pkg::sat_inc(volt_count_next);
                        if (volt_count_next > debounce_reg)
                            fault_next = 1'b1;
                    end
                    else
                    begin
                        volt_count_next = '0;
                        mode_next       = MODE_CONTROL;
                        if (!control_reg)
                            feedback_bits_next = {1'b0, b_joins_w};
                        else
                            feedback_bits_next = {1'b0, !in_middle};
                    end
                end
            end
            MODE_CONTROL:
            begin
                if (pending_ten_ms_next)
                begin
                    pending_ten_ms_next = 1'b0;
                    if (supply_bad)
                    begin
                        volt_count_next = ats_pkg::sat_inc(volt_count_next);
                        if (volt_count_next > debounce_reg)
                            mode_next = MODE_VOLTCHECK;
                    end
                    else if (control_reg)
                    begin
                        high_count_next = ats_pkg::sat_inc(high_count_next);
                        low_count_next  = '0;
                        if (high_count_next > debounce_reg)
                        begin
                            high_count_next    = '0;
                            low_count_next     = '0;
                            confirm_count_next = '0;
                            mode_next          = MODE_HIGH;
                        end
                    end
                    else
                    begin
                        high_count_next = '0;
                        low_count_next  = ats_pkg::sat_inc(low_count_next);
                        if (low_count_next > debounce_reg)
                        begin
                            high_count_next    = '0;
                            low_count_next     = '0;
                            confirm_count_next = '0;
                            mode_next          = MODE_LOW;
                        end
                    end
                end
            end
            MODE_HIGH, MODE_LOW:
            begin
                if (pending_ten_ms_next)
                begin
                    pending_ten_ms_next = 1'b0;
                    feedback_bits_next[ats_pkg::FB_OE] = 1'b1;
                    if (feedback_reg == (mode_reg == MODE_HIGH))
                    begin
                        if (confirm_count_next < debounce_reg)
                            confirm_count_next = ats_pkg::sat_inc(confirm_count_next);
                        else if (mode_reg == MODE_HIGH)
                        begin
                            mode_next                      = MODE_RUN_FWD;
                            relay_next[ats_pkg::RELAY_TMR] = 1'b1;
                            relay_next[ats_pkg::RELAY_FWD] = 1'b1;
                        end
                        else
                        begin
                            mode_next                      = MODE_RUN_BWD;
                            relay_next[ats_pkg::RELAY_TMR] = 1'b1;
                            relay_next[ats_pkg::RELAY_BWD] = 1'b1;
                        end
                    end
                    else
                    begin
                        high_count_next    = '0;
                        low_count_next     = '0;
                        confirm_count_next = '0;
                        mode_next          = MODE_CONTROL;
                    end
                end
            end
            MODE_RUN_FWD, MODE_RUN_BWD, MODE_WRAP_UP:
            begin
                // leave the run once the window is reached or the relay drops; wrap-up always leaves
                if ((mode_reg == MODE_WRAP_UP)
                    || (mode_reg == MODE_RUN_FWD
                        && (!relay_next[ats_pkg::RELAY_FWD] || in_middle))
                    || (mode_reg == MODE_RUN_BWD
                        && (!relay_next[ats_pkg::RELAY_BWD] || b_joins_w)))
                begin
                    if (mode_reg == MODE_WRAP_UP)
                        relay_next = 3'b000;
                    else
                    begin
                        relay_next[ats_pkg::RELAY_TMR] = 1'b0;
                        relay_next[ats_pkg::RELAY_FWD] = 1'b0;
                        relay_next[ats_pkg::RELAY_BWD] = 1'b0;
                    end
                    feedback_bits_next[ats_pkg::FB_OE] = 1'b1;
                    unique case (mode_reg)
                        MODE_RUN_FWD: feedback_bits_next[ats_pkg::FB_DRV] = 1'b0;
                        MODE_RUN_BWD: feedback_bits_next[ats_pkg::FB_DRV] = 1'b1;
                        default:      feedback_bits_next[ats_pkg::FB_DRV] = !control_reg;
                    endcase
                    high_count_next = '0;
                    low_count_next  = '0;
                    if (fault_next)
                    begin
                        fault_next = 1'b0;
                        mode_next  = MODE_VOLTCHECK;
                    end
                    else
                        mode_next = MODE_CONTROL;
                end
            end
            MODE_IDLE:
            begin
            end
        endcase
    end

    // input register and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            over_voltage_reg  <= ats_pkg::OVER_VOLTAGE_RESET;
            under_voltage_reg <= ats_pkg::UNDER_VOLTAGE_RESET;
            signal_high_reg   <= ats_pkg::SIGNAL_HIGH_RESET;
            signal_low_reg    <= ats_pkg::SIGNAL_LOW_RESET;
            debounce_reg      <= ats_pkg::DEBOUNCE_RESET;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    ats_pkg::CFG_OVER_VOLTAGE:  over_voltage_reg  <= cfg_data;
                    ats_pkg::CFG_UNDER_VOLTAGE: under_voltage_reg <= cfg_data;
                    ats_pkg::CFG_SIGNAL_HIGH:   signal_high_reg   <= cfg_data;
                    ats_pkg::CFG_SIGNAL_LOW:    signal_low_reg    <= cfg_data;
                    ats_pkg::CFG_DEBOUNCE:      debounce_reg      <= cfg_data[ats_pkg::COUNT_W-1:0];
                    default:                    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            tick_second_reg   <= tick_second;
            tick_ten_ms_reg   <= tick_ten_ms;
            relay_timeout_reg <= relay_timeout;
            supply_reg        <= supply_level;
            control_reg       <= control_level;
            feedback_reg      <= feedback_level;
            signal_b_reg      <= signal_b;
            signal_y_reg      <= signal_y;
            signal_w_reg      <= signal_w;
        end
    end

    // sequencer state and result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= MODE_VOLTCHECK;
            pending_second_reg <= 1'b0;
            pending_ten_ms_reg <= 1'b0;
            volt_count_reg     <= '0;
            high_count_reg     <= '0;
            low_count_reg      <= '0;
            confirm_count_reg  <= '0;
            fault_reg          <= 1'b0;
            recheck_reg        <= 1'b0;
            relay_reg          <= '0;
            feedback_bits_reg  <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (step)
            begin
                mode_reg           <= mode_next;
                pending_second_reg <= pending_second_next;
                pending_ten_ms_reg <= pending_ten_ms_next;
                volt_count_reg     <= volt_count_next;
                high_count_reg     <= high_count_next;
                low_count_reg      <= low_count_next;
                confirm_count_reg  <= confirm_count_next;
                fault_reg          <= fault_next;
                recheck_reg        <= recheck_next;
                relay_reg          <= relay_next;
                feedback_bits_reg  <= feedback_bits_next;
            end
        end
    end

    // the state registers are the result word
    assign out_valid              = out_valid_reg;
    assign mode                   = mode_reg;
    assign relay_forward          = relay_reg[ats_pkg::RELAY_FWD];
    assign relay_backward         = relay_reg[ats_pkg::RELAY_BWD];
    assign relay_timer_on         = relay_reg[ats_pkg::RELAY_TMR];
    assign feedback_drive         = feedback_bits_reg[ats_pkg::FB_DRV];
    assign feedback_output_enable = feedback_bits_reg[ats_pkg::FB_OE];
    assign power_fault            = fault_reg;

    // never both relays at once
    assert property (@(posedge clk) disable iff (!rst_n)
        !(relay_reg[ats_pkg::RELAY_FWD] && relay_reg[ats_pkg::RELAY_BWD]))
        else $error("both relays driven");

    // a running relay always has its timer running
    assert property (@(posedge clk) disable iff (!rst_n)
        (relay_reg[ats_pkg::RELAY_FWD] || relay_reg[ats_pkg::RELAY_BWD])
        |-> relay_reg[ats_pkg::RELAY_TMR])
        else $error("relay on without timer");

    // state moves only on a pass
    assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(mode_reg) && $stable(relay_reg) && $stable(fault_reg))
        else $error("state changed without a pass");

    // every pass lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("pass result lost");

    // a stalled input word is held
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input word dropped while stalled");

endmodule

/* tb/tb_actuator_test_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_actuator_test_sequencer
// Drives loop-pass words into the actuator test sequencer and checks every
// status word against a cycle-free model of the mode sequencer and supply
// monitor (or a typed expectation for the first directed rows), across several
// limit settings with random flow control.
module tb_actuator_test_sequencer;

    localparam int NUM_DIRECTED    = 20;
    localparam int NUM_PHASES      = 7;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int END_TAIL        = 10;

    typedef enum logic [ats_pkg::MODE_W-1:0] {
        MODE_VOLTCHECK = 3'd0,
        MODE_IDLE      = 3'd1,
        MODE_CONTROL   = 3'd2,
        MODE_HIGH      = 3'd3,
        MODE_LOW       = 3'd4,
        MODE_RUN_BWD   = 3'd5,
        MODE_RUN_FWD   = 3'd6,
        MODE_WRAP_UP   = 3'd7
    } seq_mode_t;

    typedef struct packed {
        logic                        tick_s;
        logic                        tick_t;
        logic                        timeout;
        logic [ats_pkg::LEVEL_W-1:0] supply;
        logic                        ctl;
        logic                        fb;
        logic [ats_pkg::LEVEL_W-1:0] b;
        logic [ats_pkg::LEVEL_W-1:0] y;
        logic [ats_pkg::LEVEL_W-1:0] w;
    } pass_t;

    typedef struct packed {
        seq_mode_t mode;
        logic      fwd;
        logic      bwd;
        logic      tmr;
        logic      drv;
        logic      oe;
        logic      fault;
    } status_t;

    typedef struct packed {
        pass_t   p;
        logic    typed;
        status_t want;
    } stim_row_t;

    typedef struct packed {
        logic                        rnd;
        logic [ats_pkg::LEVEL_W-1:0] over;
        logic [ats_pkg::LEVEL_W-1:0] under;
        logic [ats_pkg::LEVEL_W-1:0] high;
        logic [ats_pkg::LEVEL_W-1:0] low;
        logic [ats_pkg::COUNT_W-1:0] db;
        logic [15:0]                 items;
        logic [7:0]                  noise_pct;
        logic                        idle;
    } phase_t;

    localparam status_t ST_VOLTCHECK =
        '{MODE_VOLTCHECK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam status_t ST_CONTROL =
        '{MODE_CONTROL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

    // fields: second, ten ms, timeout, supply, control, feedback, b, y, w
    localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{'{1'b0, 1'b0, 1'b0, 12'd0,    1'b0, 1'b0, 12'd0,    12'd0,    12'd0},
          1'b1, ST_VOLTCHECK},
        '{'{1'b0, 1'b1, 1'b0, 12'd4095, 1'b0, 1'b0, 12'd0,    12'd0,    12'd0},
          1'b1, ST_VOLTCHECK},
        '{'{1'b0, 1'b1, 1'b0, 12'd2249, 1'b0, 1'b0, 12'd0,    12'd0,    12'd0},
          1'b1, ST_VOLTCHECK},
        '{'{1'b0, 1'b1, 1'b0, 12'd2250, 1'b1, 1'b0, 12'd4095, 12'd0,    12'd0},
          1'b1, ST_CONTROL},
        // control high debounce
        '{'{1'b1, 1'b1, 1'b0, 12'd3190, 1'b1, 1'b0, 12'd1000, 12'd2999, 12'd999},
          1'b0, ST_VOLTCHECK},
        '{'{1'b0, 1'b1, 1'b0, 12'd3190, 1'b1, 1'b0, 12'd2999, 12'd3000, 12'd0},
          1'b0, ST_VOLTCHECK},
        '{'{1'b0, 1'b1, 1'b0, 12'd3190, 1'b1, 1'b0, 12'd3000, 12'd999,  12'd1000},
          1'b0, ST_VOLTCHECK},
        '{'{1'b0, 1'b1, 1'b0, 12'd3190, 1'b1, 1'b0, 12'd0,    12'd4095, 12'd0},
          1'b0, ST_VOLTCHECK},
        '{'{1'b0, 1'b1, 1'b0, 12'd3190, 1'b1, 1'b0, 12'd2048, 12'd2048, 12'd2048},
          1'b0, ST_VOLTCHECK},
        '{'{1'b0, 1'b1, 1'b0, 12'd3190, 1'b1, 1'b0, 12'd1365, 12'd2730, 12'd1365},
          1'b0, ST_VOLTCHECK},
        // feedback confirm, then forward run
        '{'{1'b0, 1'b1, 1'b0, 12'd2800, 1'b1, 1'b1, 12'd0,    12'd0,    12'd0},
          1'b0, ST_VOLTCHECK},
        '{'{1'b0, 1'b1, 1'b0, 12'd2800, 1'b1, 1'b1, 12'd100,  12'd0,    12'd0},
          1'b0, ST_VOLTCHECK},
        '{'{1'b0, 1'b1, 1'b0, 12'd2800, 1'b1, 1'b1, 12'd200,  12'd0,    12'd0},
          1'b0, ST_VOLTCHECK},
        '{'{1'b0, 1'b1, 1'b0, 12'd2800, 1'b1, 1'b1, 12'd300,  12'd0,    12'd0},
          1'b0, ST_VOLTCHECK},
        '{'{1'b0, 1'b1, 1'b0, 12'd2800, 1'b1, 1'b1, 12'd400,  12'd0,    12'd0},
          1'b0, ST_VOLTCHECK},
        '{'{1'b0, 1'b1, 1'b0, 12'd2800, 1'b1, 1'b1, 12'd500,  12'd0,    12'd0},
          1'b0, ST_VOLTCHECK},
        // position window reached on the edge of the low level
        '{'{1'b0, 1'b0, 1'b0, 12'd2800, 1'b1, 1'b0, 12'd4095, 12'd0,    12'd999},
          1'b0, ST_VOLTCHECK},
        // out-of-window supply starts a recheck
        '{'{1'b1, 1'b1, 1'b0, 12'd3191, 1'b0, 1'b0, 12'd0,    12'd0,    12'd0},
          1'b0, ST_VOLTCHECK},
        '{'{1'b1, 1'b1, 1'b1, 12'd4095, 1'b1, 1'b1, 12'd4095, 12'd4095, 12'd4095},
          1'b0, ST_VOLTCHECK},
        '{'{1'b0, 1'b1, 1'b0, 12'd0,    1'b0, 1'b1, 12'd4095, 12'd4095, 12'd4095},
          1'b0, ST_VOLTCHECK}
    };

    // random, over, under, high, low, debounce, words, noise %, idling
    localparam phase_t PHASES [NUM_PHASES] = '{
        '{1'b0, 12'd3190, 12'd2250, 12'd3000, 12'd1000, 8'd5,   16'd80,  8'd15, 1'b1},
        '{1'b0, 12'd3190, 12'd2250, 12'd3000, 12'd1000, 8'd1,   16'd110, 8'd15, 1'b1},
        '{1'b0, 12'd4095, 12'd0,    12'd4095, 12'd4095, 8'd2,   16'd80,  8'd15, 1'b1},
        '{1'b0, 12'd0,    12'd4095, 12'd0,    12'd0,    8'd255, 16'd300, 8'd0,  1'b0},
        '{1'b1, 12'd0,    12'd0,    12'd0,    12'd0,    8'd0,   16'd100, 8'd15, 1'b1},
        '{1'b0, 12'd3190, 12'd2250, 12'd3000, 12'd1000, 8'd255, 16'd320, 8'd0,  1'b0},
        '{1'b1, 12'd0,    12'd0,    12'd0,    12'd0,    8'd0,   16'd100, 8'd20, 1'b1}
    };

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_valid;
    logic                          cfg_ready;
    ats_pkg::cfg_index_t           cfg_index;
    logic [ats_pkg::LEVEL_W-1:0]   cfg_data;
    logic                          in_valid;
    logic                          in_ready;
    logic                          tick_second;
    logic                          tick_ten_ms;
    logic                          relay_timeout;
    logic [ats_pkg::LEVEL_W-1:0]   supply_level;
    logic                          control_level;
    logic                          feedback_level;
    logic [ats_pkg::LEVEL_W-1:0]   signal_b;
    logic [ats_pkg::LEVEL_W-1:0]   signal_y;
    logic [ats_pkg::LEVEL_W-1:0]   signal_w;
    logic                          out_valid;
    logic                          out_ready;
    logic [ats_pkg::MODE_W-1:0]    mode;
    logic                          relay_forward;
    logic                          relay_backward;
    logic                          relay_timer_on;
    logic                          feedback_drive;
    logic                          feedback_output_enable;
    logic                          power_fault;

    // model copy of the limits
    logic [ats_pkg::LEVEL_W-1:0]   lim_over;
    logic [ats_pkg::LEVEL_W-1:0]   lim_under;
    logic [ats_pkg::LEVEL_W-1:0]   lim_high;
    logic [ats_pkg::LEVEL_W-1:0]   lim_low;
    logic [ats_pkg::COUNT_W-1:0]   lim_debounce;

    // model copy of the sequencer state
    seq_mode_t                     seq_mode;
    logic                          pend_sec;
    logic                          pend_tick;
    logic [ats_pkg::COUNT_W-1:0]   volt_cnt;
    logic [ats_pkg::COUNT_W-1:0]   high_cnt;
    logic [ats_pkg::COUNT_W-1:0]   low_cnt;
    logic [ats_pkg::COUNT_W-1:0]   conf_cnt;
    logic                          fault;
    logic                          recheck;
    logic [2:0]                    relay_st;
    logic [1:0]                    fb_st;

    status_t                       expected_status [$];
    int                            mismatches;

    // stimulus knobs, set per phase
    int                            noise_pct;
    int                            tick_pct;
    int                            flip_pct;
    bit                            idling_on;
    bit                            held_control;
    bit                            hold_off_request;

    actuator_test_sequencer dut
    (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .cfg_index              (cfg_index),
        .cfg_data               (cfg_data),
        .in_valid               (in_valid),
        .in_ready               (in_ready),
        .tick_second            (tick_second),
        .tick_ten_ms            (tick_ten_ms),
        .relay_timeout          (relay_timeout),
        .supply_level           (supply_level),
        .control_level          (control_level),
        .feedback_level         (feedback_level),
        .signal_b               (signal_b),
        .signal_y               (signal_y),
        .signal_w               (signal_w),
        .out_valid              (out_valid),
        .out_ready              (out_ready),
        .mode                   (mode),
        .relay_forward          (relay_forward),
        .relay_backward         (relay_backward),
        .relay_timer_on         (relay_timer_on),
        .feedback_drive         (feedback_drive),
        .feedback_output_enable (feedback_output_enable),
        .power_fault            (power_fault)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [ats_pkg::COUNT_W-1:0] bump(
        input logic [ats_pkg::COUNT_W-1:0] c);
        return (c == {ats_pkg::COUNT_W{1'b1}}) ? c : c + 8'd1;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic end_run();
        high_cnt = '0;
        low_cnt  = '0;
        if (fault)
        begin
            fault    = 1'b0;
            seq_mode = MODE_VOLTCHECK;
        end
        else
        begin
            seq_mode = MODE_CONTROL;
        end
    endtask

    // one loop pass of the sequencer
    task automatic advance_sequencer(input pass_t p, output status_t s);
        logic bad;
        logic mid;
        logic joins;
        logic want;
        bad   = (p.supply > lim_over) || (p.supply < lim_under);
        mid   = (p.b >= lim_high) && (p.w < lim_low) && (p.y < lim_low);
        joins = (p.y >= lim_high) && (p.b < lim_low) && (p.w < lim_low);

        if (p.tick_s)
            pend_sec = 1'b1;
        if (p.tick_t)
            pend_tick = 1'b1;
        if (p.timeout)
            relay_st = '0;

        // supply monitor, runs outside voltage check until a fault latches
        if (seq_mode != MODE_VOLTCHECK && !fault)
        begin
            if (!recheck)
            begin
                if (pend_sec)
                begin
                    pend_sec = 1'b0;
                    if (bad)
                    begin
                        volt_cnt = '0;
                        recheck  = 1'b1;
                    end
                end
            end
            else if (pend_tick)
            begin
                pend_tick = 1'b0;
                if (bad)
                begin
                    volt_cnt = bump(volt_cnt);
                    if (volt_cnt > lim_debounce)
                    begin
                        fault   = 1'b1;
                        recheck = 1'b0;
                    end
                end
                else
                begin
                    volt_cnt = '0;
                    recheck  = 1'b0;
                end
            end
        end

        case (seq_mode)
            MODE_VOLTCHECK:
            begin
                if (pend_tick)
                begin
                    pend_tick = 1'b0;
                    if (bad)
                    begin
                        volt_cnt = bump(volt_cnt);
                        if (volt_cnt > lim_debounce)
                            fault = 1'b1;
                    end
                    else
                    begin
                        volt_cnt = '0;
                        seq_mode = MODE_CONTROL;
                        fb_st    = '0;
                        fb_st[ats_pkg::FB_DRV] = p.ctl ? !mid : joins;
                    end
                end
            end
            MODE_CONTROL:
            begin
                if (pend_tick)
                begin
                    pend_tick = 1'b0;
                    if (bad)
                    begin
                        volt_cnt = bump(volt_cnt);
                        if (volt_cnt > lim_debounce)
                            seq_mode = MODE_VOLTCHECK;
                    end
                    else if (p.ctl)
                    begin
                        high_cnt = bump(high_cnt);
                        low_cnt  = '0;
                        if (high_cnt > lim_debounce)
                        begin
                            high_cnt = '0;
                            conf_cnt = '0;
                            seq_mode = MODE_HIGH;
                        end
                    end
                    else
                    begin
                        high_cnt = '0;
                        low_cnt  = bump(low_cnt);
                        if (low_cnt > lim_debounce)
                        begin
                            low_cnt  = '0;
                            conf_cnt = '0;
                            seq_mode = MODE_LOW;
                        end
                    end
                end
            end
            MODE_HIGH, MODE_LOW:
            begin
                if (pend_tick)
                begin
                    want      = (seq_mode == MODE_HIGH);
                    pend_tick = 1'b0;
                    fb_st[ats_pkg::FB_OE] = 1'b1;
                    if (p.fb == want)
                    begin
                        if (conf_cnt < lim_debounce)
                        begin
                            conf_cnt = bump(conf_cnt);
                        end
                        else if (want)
                        begin
                            seq_mode = MODE_RUN_FWD;
                            relay_st[ats_pkg::RELAY_TMR] = 1'b1;
                            relay_st[ats_pkg::RELAY_FWD] = 1'b1;
                        end
                        else
                        begin
                            seq_mode = MODE_RUN_BWD;
                            relay_st[ats_pkg::RELAY_TMR] = 1'b1;
                            relay_st[ats_pkg::RELAY_BWD] = 1'b1;
                        end
                    end
                    else
                    begin
                        high_cnt = '0;
                        low_cnt  = '0;
                        conf_cnt = '0;
                        seq_mode = MODE_CONTROL;
                    end
                end
            end
            MODE_RUN_FWD:
            begin
                if (!relay_st[ats_pkg::RELAY_FWD] || mid)
                begin
                    relay_st[ats_pkg::RELAY_TMR] = 1'b0;
                    relay_st[ats_pkg::RELAY_FWD] = 1'b0;
                    fb_st[ats_pkg::FB_OE]  = 1'b1;
                    fb_st[ats_pkg::FB_DRV] = 1'b0;
                    end_run();
                end
            end
            MODE_RUN_BWD:
            begin
                if (!relay_st[ats_pkg::RELAY_BWD] || joins)
                begin
                    relay_st[ats_pkg::RELAY_TMR] = 1'b0;
                    relay_st[ats_pkg::RELAY_BWD] = 1'b0;
                    fb_st[ats_pkg::FB_OE]  = 1'b1;
                    fb_st[ats_pkg::FB_DRV] = 1'b1;
                    end_run();
                end
            end
            MODE_WRAP_UP:
            begin
                relay_st = '0;
                fb_st[ats_pkg::FB_OE]  = 1'b1;
                fb_st[ats_pkg::FB_DRV] = !p.ctl;
                end_run();
            end
            default:
            begin
            end
        endcase

        s.mode  = seq_mode;
        s.fwd   = relay_st[ats_pkg::RELAY_FWD];
        s.bwd   = relay_st[ats_pkg::RELAY_BWD];
        s.tmr   = relay_st[ats_pkg::RELAY_TMR];
        s.drv   = fb_st[ats_pkg::FB_DRV];
        s.oe    = fb_st[ats_pkg::FB_OE];
        s.fault = fault;
    endtask

    // puts the position lines into one of the two windows where it can
    task automatic place_window(inout pass_t p, input bit joins);
        logic [ats_pkg::LEVEL_W-1:0] hi_line;
        hi_line = 12'($urandom_range(4095, lim_high));
        if (joins)
            p.y = hi_line;
        else
            p.b = hi_line;
        if (lim_low != 0)
        begin
            p.w = 12'($urandom_range(lim_low - 1, 0));
            if (joins)
                p.b = 12'($urandom_range(lim_low - 1, 0));
            else
                p.y = 12'($urandom_range(lim_low - 1, 0));
        end
    endtask

    task automatic compose_pass(output pass_t p);
        p.b = 12'($urandom_range(4095, 0));
        p.y = 12'($urandom_range(4095, 0));
        p.w = 12'($urandom_range(4095, 0));
        if ($urandom_range(0, 99) < noise_pct)
        begin
            p.tick_s  = 1'($urandom_range(0, 1));
            p.tick_t  = 1'($urandom_range(0, 1));
            p.timeout = 1'($urandom_range(0, 1));
            p.supply  = 12'($urandom_range(4095, 0));
            p.ctl     = 1'($urandom_range(0, 1));
            p.fb      = 1'($urandom_range(0, 1));
            return;
        end

        p.tick_s  = ($urandom_range(0, 99) < 8);
        p.tick_t  = ($urandom_range(0, 99) < tick_pct);
        p.timeout = ($urandom_range(0, 99) < 2);
        if ($urandom_range(0, 99) < 92 && lim_under <= lim_over)
            p.supply = 12'($urandom_range(lim_over, lim_under));
        else if (lim_over != 12'hFFF && (lim_under == 0 || $urandom_range(0, 1) == 1))
            p.supply = 12'($urandom_range(4095, lim_over + 1));
        else if (lim_under != 0)
            p.supply = 12'($urandom_range(lim_under - 1, 0));
        else
            p.supply = 12'($urandom_range(4095, 0));

        if ($urandom_range(0, 99) < flip_pct)
            held_control = !held_control;
        p.ctl = held_control;
        p.fb  = 1'($urandom_range(0, 1));

        case (seq_mode)
            MODE_HIGH, MODE_LOW:
                if ($urandom_range(0, 99) < 95)
                    p.fb = (seq_mode == MODE_HIGH);
            MODE_RUN_FWD:
                if ($urandom_range(0, 99) < 15)
                    place_window(p, 1'b0);
            MODE_RUN_BWD:
                if ($urandom_range(0, 99) < 15)
                    place_window(p, 1'b1);
            MODE_VOLTCHECK:
                // window decides the initial feedback level
                case ($urandom_range(0, 2))
                    0: place_window(p, 1'b0);
                    1: place_window(p, 1'b1);
                    default:
                    begin
                    end
                endcase
            default:
            begin
            end
        endcase
    endtask

    task automatic feed_pass(input pass_t p, input logic typed, input status_t want);
        int      gap;
        status_t predicted;
        gap = idling_on ? gap_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        tick_second    <= p.tick_s;
        tick_ten_ms    <= p.tick_t;
        relay_timeout  <= p.timeout;
        supply_level   <= p.supply;
        control_level  <= p.ctl;
        feedback_level <= p.fb;
        signal_b       <= p.b;
        signal_y       <= p.y;
        signal_w       <= p.w;
        do
            @(posedge clk);
        while (!in_ready);
        advance_sequencer(p, predicted);
        expected_status.push_back(typed ? want : predicted);
    endtask

    // leaves cfg_valid high, the caller drops it after the last write
    task automatic write_limit(input ats_pkg::cfg_index_t idx,
                               input logic [ats_pkg::LEVEL_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            ats_pkg::CFG_OVER_VOLTAGE:  lim_over     = val;
            ats_pkg::CFG_UNDER_VOLTAGE: lim_under    = val;
            ats_pkg::CFG_SIGNAL_HIGH:   lim_high     = val;
            ats_pkg::CFG_SIGNAL_LOW:    lim_low      = val;
            ats_pkg::CFG_DEBOUNCE:      lim_debounce = val[ats_pkg::COUNT_W-1:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic check_status();
        status_t want;
        if (expected_status.size() == 0)
        begin
            report_mismatch("unexpected status word, mode", int'(mode), 0);
            return;
        end
        want = expected_status.pop_front();
        if (mode !== want.mode)
            report_mismatch("mode", int'(mode), int'(want.mode));
        if (relay_forward !== want.fwd)
            report_mismatch("relay_forward", int'(relay_forward), int'(want.fwd));
        if (relay_backward !== want.bwd)
            report_mismatch("relay_backward", int'(relay_backward), int'(want.bwd));
        if (relay_timer_on !== want.tmr)
            report_mismatch("relay_timer_on", int'(relay_timer_on), int'(want.tmr));
        if (feedback_drive !== want.drv)
            report_mismatch("feedback_drive", int'(feedback_drive), int'(want.drv));
        if (feedback_output_enable !== want.oe)
            report_mismatch("feedback_output_enable", int'(feedback_output_enable),
                            int'(want.oe));
        if (power_fault !== want.fault)
            report_mismatch("power_fault", int'(power_fault), int'(want.fault));
    endtask

    // status side: check accepted words, stall at random
    initial
    begin : status_sink
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                check_status();
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                stall_left = HOLD_OFF_CYCLES;
            end
            if (stall_left == 0 && idling_on && $urandom_range(0, 3) == 0)
                stall_left = gap_len();
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial
    begin : stimulus
        phase_t                      cur;
        pass_t                       p;
        logic [ats_pkg::LEVEL_W-1:0] over_v;
        logic [ats_pkg::LEVEL_W-1:0] under_v;
        logic [ats_pkg::LEVEL_W-1:0] high_v;
        logic [ats_pkg::LEVEL_W-1:0] low_v;
        logic [ats_pkg::COUNT_W-1:0] db_v;

        mismatches       = 0;
        noise_pct        = 0;
        tick_pct         = 100;
        flip_pct         = 0;
        idling_on        = 1'b1;
        held_control     = 1'b1;
        hold_off_request = 1'b0;

        lim_over     = ats_pkg::OVER_VOLTAGE_RESET;
        lim_under    = ats_pkg::UNDER_VOLTAGE_RESET;
        lim_high     = ats_pkg::SIGNAL_HIGH_RESET;
        lim_low      = ats_pkg::SIGNAL_LOW_RESET;
        lim_debounce = ats_pkg::DEBOUNCE_RESET;
        seq_mode     = MODE_VOLTCHECK;
        pend_sec     = 1'b0;
        pend_tick    = 1'b0;
        volt_cnt     = '0;
        high_cnt     = '0;
        low_cnt      = '0;
        conf_cnt     = '0;
        fault        = 1'b0;
        recheck      = 1'b0;
        relay_st     = '0;
        fb_st        = '0;

        rst_n          <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= ats_pkg::CFG_OVER_VOLTAGE;
        cfg_data       <= '0;
        in_valid       <= 1'b0;
        tick_second    <= 1'b0;
        tick_ten_ms    <= 1'b0;
        relay_timeout  <= 1'b0;
        supply_level   <= '0;
        control_level  <= 1'b0;
        feedback_level <= 1'b0;
        signal_b       <= '0;
        signal_y       <= '0;
        signal_w       <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            feed_pass(DIRECTED_ROWS[i].p, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            cur = PHASES[ph];
            // limits only change with the pipeline empty
            in_valid <= 1'b0;
            while (expected_status.size() != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);

            over_v  = cur.over;
            under_v = cur.under;
            high_v  = cur.high;
            low_v   = cur.low;
            db_v    = cur.db;
            if (cur.rnd)
            begin
                over_v  = 12'($urandom_range(4095, 2048));
                under_v = 12'($urandom_range(2047, 0));
                high_v  = 12'($urandom_range(4095, 1));
                low_v   = 12'($urandom_range(4095, 1));
                db_v    = 8'($urandom_range(12, 1));
            end
            write_limit(ats_pkg::CFG_OVER_VOLTAGE, over_v);
            write_limit(ats_pkg::CFG_UNDER_VOLTAGE, under_v);
            write_limit(ats_pkg::CFG_SIGNAL_HIGH, high_v);
            write_limit(ats_pkg::CFG_SIGNAL_LOW, low_v);
            write_limit(ats_pkg::CFG_DEBOUNCE,
                        {{(ats_pkg::LEVEL_W-ats_pkg::COUNT_W){1'b0}}, db_v});
            cfg_valid <= 1'b0;

            noise_pct = cur.noise_pct;
            tick_pct  = (cur.noise_pct == 0) ? 100 : 85;
            flip_pct  = (cur.noise_pct == 0) ? 0 : 3;
            idling_on = cur.idle;
            // long receiver stall while words keep coming, fills the block
            if (ph == 1 || ph == 4)
                hold_off_request = 1'b1;

            for (int k = 0; k < cur.items; k++)
            begin
                compose_pass(p);
                feed_pass(p, 1'b0, ST_VOLTCHECK);
            end
        end
        in_valid <= 1'b0;

        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (END_TAIL) @(posedge clk);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
